FILE: hdl/bmhq_pkg.sv
// bmhq_pkg: shared types and constants of the binary min-heap queue
// no dependencies; used by bmhq_ctrl, bmhq_datapath and the top level
`timescale 1ns / 1ps

package bmhq_pkg;

    // fixed port widths
    localparam int OP_W       = 2;
    localparam int KEY_PORT_W = 32;
    localparam int TAG_W      = 9;
    localparam int COUNT_W    = 8;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    // read address selection of the two heap read ports
    typedef enum logic [1:0] {
        RD_ROOT_LAST = 2'd0,
        RD_PARENT    = 2'd1,
        RD_CHILDREN  = 2'd2
    } t_rd_mode;

    // source of the entry written at the current slot
    typedef enum logic [1:0] {
        WR_MOVING = 2'd0,
        WR_PARENT = 2'd1,
        WR_CHILD  = 2'd2
    } t_wr_src;

    // controller to datapath
    typedef struct packed {
        logic     load;       // capture item, clear result fields
        logic     set_empty;  // flag remove from empty heap
        logic     set_ovf;    // flag insert into full heap
        logic     ins_start;  // grow heap, start at new last slot
        logic     fill_clr;   // drop all entries
        logic     rm_take;    // take root, last entry becomes moving entry
        logic     pos_up;     // step to parent slot
        logic     pos_child;  // step to chosen child slot
        logic     wr_en;      // write entry at current slot
        t_wr_src  wr_src;
        t_rd_mode rd_mode;
        logic     out_load;   // move result into output register
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic fill_zero;
        logic fill_full;
        logic pos_root;
        logic up_go;          // moving key <= parent key
        logic dn_has_child;   // current slot has at least one child
        logic dn_stop;        // moving key < chosen child key
    } t_dp_status;

endpackage

FILE: hdl/bmhq_ctrl.sv
// bmhq_ctrl: sequencing state machine of the heap queue
// depends on bmhq_pkg for command, status and operation types
`timescale 1ns / 1ps

module bmhq_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [bmhq_pkg::OP_W-1:0]    i_operation,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    input  bmhq_pkg::t_dp_status         i_sts,
    output bmhq_pkg::t_ctrl_cmd          o_cmd
);
    import bmhq_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_UP_RD   = 7'b0000010,
        ST_UP_CMP  = 7'b0000100,
        ST_RM_TAKE = 7'b0001000,
        ST_DN_RD   = 7'b0010000,
        ST_DN_CMP  = 7'b0100000,
        ST_DONE    = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    // output register can take a result when empty or being drained
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    // next state and commands
    always_comb begin
        n_state         = r_state;
        o_cmd.load      = 1'b0;
        o_cmd.set_empty = 1'b0;
        o_cmd.set_ovf   = 1'b0;
        o_cmd.ins_start = 1'b0;
        o_cmd.fill_clr  = 1'b0;
        o_cmd.rm_take   = 1'b0;
        o_cmd.pos_up    = 1'b0;
        o_cmd.pos_child = 1'b0;
        o_cmd.wr_en     = 1'b0;
        o_cmd.wr_src    = WR_MOVING;
        o_cmd.rd_mode   = RD_ROOT_LAST;
        o_cmd.out_load  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    case (t_op'(i_operation))
                        OP_INSERT: begin
                            if (i_sts.fill_full) begin
                                o_cmd.set_ovf = 1'b1;
                                n_state       = ST_DONE;
                            end else begin
                                o_cmd.ins_start = 1'b1;
                                n_state         = ST_UP_RD;
                            end
                        end
                        OP_REMOVE: begin
                            if (i_sts.fill_zero) begin
                                o_cmd.set_empty = 1'b1;
                                n_state         = ST_DONE;
                            end else begin
                                n_state = ST_RM_TAKE;
                            end
                        end
                        OP_CLEAR: begin
                            o_cmd.fill_clr = 1'b1;
                            n_state        = ST_DONE;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            // sift up: fetch parent, or settle at the root
            ST_UP_RD: begin
                o_cmd.rd_mode = RD_PARENT;
                if (i_sts.pos_root) begin
                    o_cmd.wr_en = 1'b1;
                    n_state     = ST_DONE;
                end else begin
                    n_state = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                o_cmd.wr_en = 1'b1;
                if (i_sts.up_go) begin
                    o_cmd.wr_src = WR_PARENT;
                    o_cmd.pos_up = 1'b1;
                    n_state      = ST_UP_RD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            // remove: root and last entry were read at the transfer
            ST_RM_TAKE: begin
                o_cmd.rm_take = 1'b1;
                n_state       = ST_DN_RD;
            end
            // sift down: fetch both children, or settle at a leaf
            ST_DN_RD: begin
                o_cmd.rd_mode = RD_CHILDREN;
                if (i_sts.dn_has_child) begin
                    n_state = ST_DN_CMP;
                end else begin
                    o_cmd.wr_en = 1'b1;
                    n_state     = ST_DONE;
                end
            end
            ST_DN_CMP: begin
                o_cmd.wr_en = 1'b1;
                if (i_sts.dn_stop) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.wr_src    = WR_CHILD;
                    o_cmd.pos_child = 1'b1;
                    n_state         = ST_DN_RD;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: hdl/bmhq_datapath.sv
// bmhq_datapath: heap memory, slot pointer, fill count and result registers
// depends on bmhq_pkg for command, status and select types
`timescale 1ns / 1ps

module bmhq_datapath #(
    parameter int HEAP_SLOTS = 256,
    parameter int KEY_BITS   = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bmhq_pkg::t_ctrl_cmd              i_cmd,
    output bmhq_pkg::t_dp_status             o_sts,
    input  logic [bmhq_pkg::KEY_PORT_W-1:0]  i_key,
    input  logic [bmhq_pkg::TAG_W-1:0]       i_tag,
    output logic [bmhq_pkg::KEY_PORT_W-1:0]  o_out_key,
    output logic [bmhq_pkg::TAG_W-1:0]       o_out_tag,
    output logic                             o_was_empty,
    output logic                             o_overflow,
    output logic [bmhq_pkg::COUNT_W-1:0]     o_entry_count
);
    import bmhq_pkg::*;

    localparam int ADDR_W = $clog2(HEAP_SLOTS);
    localparam logic [ADDR_W-1:0] FILL_CAP = ADDR_W'(HEAP_SLOTS - 1);
    localparam logic [ADDR_W-1:0] ROOT     = ADDR_W'(1);

    // heap storage, slot 0 unused
    logic [KEY_BITS-1:0] mem_key [HEAP_SLOTS];
    logic [TAG_W-1:0]    mem_tag [HEAP_SLOTS];

    logic [ADDR_W-1:0]     r_fill;
    logic [ADDR_W-1:0]     r_pos;
    logic [KEY_BITS-1:0]   r_key;
    logic [TAG_W-1:0]      r_tag;
    logic [KEY_BITS-1:0]   r_rd_key_a, r_rd_key_b;
    logic [TAG_W-1:0]      r_rd_tag_a, r_rd_tag_b;
    logic [KEY_PORT_W-1:0] r_res_key;
    logic [TAG_W-1:0]      r_res_tag;
    logic                  r_res_empty, r_res_ovf;

    logic [ADDR_W-1:0]   w_addr_a, w_addr_b;
    logic [ADDR_W-1:0]   w_child_l, w_child_r, w_child_sel;
    logic                w_pick_right;
    logic [KEY_BITS-1:0] w_child_key;
    logic [TAG_W-1:0]    w_child_tag;
    logic [KEY_BITS-1:0] w_wr_key;
    logic [TAG_W-1:0]    w_wr_tag;

    // child slots of the current slot and the one the sift follows
    assign w_child_l    = {r_pos[ADDR_W-2:0], 1'b0};
    assign w_child_r    = {r_pos[ADDR_W-2:0], 1'b1};
    assign w_pick_right = (w_child_l < r_fill) && (r_rd_key_a >= r_rd_key_b);
    assign w_child_sel  = w_pick_right ? w_child_r  : w_child_l;
    assign w_child_key  = w_pick_right ? r_rd_key_b : r_rd_key_a;
    assign w_child_tag  = w_pick_right ? r_rd_tag_b : r_rd_tag_a;

    // status to the controller
    assign o_sts.fill_zero    = (r_fill == '0);
    assign o_sts.fill_full    = (r_fill >= FILL_CAP);
    assign o_sts.pos_root     = (r_pos == ROOT);
    assign o_sts.up_go        = (r_key <= r_rd_key_a);
    assign o_sts.dn_has_child = (r_pos <= (r_fill >> 1));
    assign o_sts.dn_stop      = (r_key < w_child_key);

    // read address selection
    always_comb begin
        case (i_cmd.rd_mode)
            RD_PARENT: begin
                w_addr_a = r_pos >> 1;
                w_addr_b = r_fill;
            end
            RD_CHILDREN: begin
                w_addr_a = w_child_l;
                w_addr_b = w_child_r;
            end
            default: begin
                w_addr_a = ROOT;
                w_addr_b = r_fill;
            end
        endcase
    end

    // write data selection
    always_comb begin
        case (i_cmd.wr_src)
            WR_PARENT: begin
                w_wr_key = r_rd_key_a;
                w_wr_tag = r_rd_tag_a;
            end
            WR_CHILD: begin
                w_wr_key = w_child_key;
                w_wr_tag = w_child_tag;
            end
            default: begin
                w_wr_key = r_key;
                w_wr_tag = r_tag;
            end
        endcase
    end

    // heap memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem_key[r_pos] <= w_wr_key;
            mem_tag[r_pos] <= w_wr_tag;
        end
        r_rd_key_a <= mem_key[w_addr_a];
        r_rd_tag_a <= mem_tag[w_addr_a];
        r_rd_key_b <= mem_key[w_addr_b];
        r_rd_tag_b <= mem_tag[w_addr_b];
    end

    // fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.fill_clr) begin
            r_fill <= '0;
        end else if (i_cmd.ins_start) begin
            r_fill <= r_fill + ROOT;
        end else if (i_cmd.rm_take) begin
            r_fill <= r_fill - ROOT;
        end
    end

    // slot pointer and moving entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= KEY_BITS'(i_key);
            r_tag <= i_tag;
        end else if (i_cmd.rm_take) begin
            r_key <= r_rd_key_b;
            r_tag <= r_rd_tag_b;
        end
        if (i_cmd.ins_start) begin
            r_pos <= r_fill + ROOT;
        end else if (i_cmd.rm_take) begin
            r_pos <= ROOT;
        end else if (i_cmd.pos_up) begin
            r_pos <= r_pos >> 1;
        end else if (i_cmd.pos_child) begin
            r_pos <= w_child_sel;
        end
    end

    // result fields of the item at work
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_res_key   <= '0;
            r_res_tag   <= '0;
            r_res_empty <= i_cmd.set_empty;
            r_res_ovf   <= i_cmd.set_ovf;
        end else if (i_cmd.rm_take) begin
            r_res_key <= KEY_PORT_W'(r_rd_key_a);
            r_res_tag <= r_rd_tag_a;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_out_key     <= r_res_key;
            o_out_tag     <= r_res_tag;
            o_was_empty   <= r_res_empty;
            o_overflow    <= r_res_ovf;
            o_entry_count <= COUNT_W'(r_fill);
        end
    end

endmodule

FILE: hdl/binary_min_heap_queue_top.sv
// Binary min-heap priority queue of (key, tag) entries held in one on-chip memory
// with two registered read ports. Each transfer inserts, removes the minimum,
// or clears, and gives one result with the removed entry, the empty and
// overflow flags and the entry count after the operation. One item is worked
// at a time; for each heap level the sift passes there is one memory read,
// then compare and write back, and the sift passes at most log2(HEAP_SLOTS)-1
// levels. Clear, no-op, remove from empty and insert into full do no sift.
// A stalled output side holds the item in its final state until the output
// register frees up. A finished result waits in the output register while
// the next item is taken.
// The heap holds HEAP_SLOTS-1 entries; keys are kept at KEY_BITS bits.
// depends on bmhq_pkg, bmhq_ctrl and bmhq_datapath
`timescale 1ns / 1ps

module binary_min_heap_queue_top #(
    parameter int HEAP_SLOTS = 256,
    parameter int KEY_BITS   = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [bmhq_pkg::OP_W-1:0]        i_operation,
    input  logic [bmhq_pkg::KEY_PORT_W-1:0]  i_key,
    input  logic [bmhq_pkg::TAG_W-1:0]       i_tag,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [bmhq_pkg::KEY_PORT_W-1:0]  o_out_key,
    output logic [bmhq_pkg::TAG_W-1:0]       o_out_tag,
    output logic                             o_was_empty,
    output logic                             o_overflow,
    output logic [bmhq_pkg::COUNT_W-1:0]     o_entry_count
);
    import bmhq_pkg::*;

    t_ctrl_cmd  w_cmd;
    t_dp_status w_sts;

    // sequencing
    bmhq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_operation (i_operation),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // heap storage and arithmetic
    bmhq_datapath #(
        .HEAP_SLOTS (HEAP_SLOTS),
        .KEY_BITS   (KEY_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_key         (i_key),
        .i_tag         (i_tag),
        .o_out_key     (o_out_key),
        .o_out_tag     (o_out_tag),
        .o_was_empty   (o_was_empty),
        .o_overflow    (o_overflow),
        .o_entry_count (o_entry_count)
    );

`ifndef SYNTH
    // an accepted item keeps the input side busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after transfer");

    // heap memory is written only while an item is at work
    a_write_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.wr_en |-> o_in_stall)
        else $error("heap write while idle");

    // flagged results carry no entry
    a_flag_no_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_was_empty || o_overflow) |->
            o_out_key == '0 && o_out_tag == '0 && !(o_was_empty && o_overflow))
        else $error("flagged result carries entry data");

    // empty remove reports an empty heap
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_was_empty |-> o_entry_count == '0)
        else $error("empty remove with nonzero count");
`endif

endmodule

FILE: test/binary_min_heap_queue_top_tb.sv
// binary_min_heap_queue_top_tb: self-checking bench for the min-heap priority queue
// holds its own heap model in a scoreboard class; depends on bmhq_pkg and the top level
`timescale 1ns / 1ps

module binary_min_heap_queue_top_tb;

    import bmhq_pkg::*;

    localparam int          HEAP_SLOTS    = 256;
    localparam int unsigned HEAP_CAP      = HEAP_SLOTS - 1;
    localparam int          RESET_CYCLES  = 7;
    localparam int          SETTLE_CYCLES = 40;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          CYCLE_LIMIT   = 250000;

    // one result of the queue
    typedef struct packed {
        logic [KEY_PORT_W-1:0] res_key;
        logic [TAG_W-1:0]      res_tag;
        logic                  was_empty;
        logic                  overflow;
        logic [COUNT_W-1:0]    entry_count;
    } t_heap_result;

    // heap mirror plus the queue of results still owed by the block
    class heap_scoreboard;
        bit [KEY_PORT_W-1:0] heap_key[HEAP_SLOTS];
        bit [TAG_W-1:0]      heap_tag[HEAP_SLOTS];
        int unsigned         fill;
        int unsigned         failures;
        t_heap_result        owed_results[$];

        function new();
            fill     = 0;
            failures = 0;
        endfunction

        function int unsigned pending();
            return owed_results.size();
        endfunction

        // apply one accepted transfer to the mirror and queue its result
        function void note_transfer(t_op op, logic [KEY_PORT_W-1:0] key, logic [TAG_W-1:0] tag);
            t_heap_result        res;
            bit [KEY_PORT_W-1:0] mv_key;
            bit [TAG_W-1:0]      mv_tag;
            int unsigned         pos;
            int unsigned         child;
            bit                  settled;
            res = '0;
            case (op)
                OP_INSERT: begin
                    if (fill >= HEAP_CAP) begin
                        res.overflow = 1'b1;
                    end else begin
                        fill++;
                        pos = fill;
                        // sift up, equal keys move the new entry above its parent
                        while (pos > 1 && key <= heap_key[pos / 2]) begin
                            heap_key[pos] = heap_key[pos / 2];
                            heap_tag[pos] = heap_tag[pos / 2];
                            pos = pos / 2;
                        end
                        heap_key[pos] = key;
                        heap_tag[pos] = tag;
                    end
                end
                OP_REMOVE: begin
                    if (fill == 0) begin
                        res.was_empty = 1'b1;
                    end else begin
                        mv_key = heap_key[fill];
                        mv_tag = heap_tag[fill];
                        res.res_key = heap_key[1];
                        res.res_tag = heap_tag[1];
                        fill--;
                        pos = 1;
                        settled = 1'b0;
                        // sift down, right child wins ties, stop on strictly smaller key
                        while (!settled && pos <= fill / 2) begin
                            child = 2 * pos;
                            if (child < fill && heap_key[child] >= heap_key[child + 1])
                                child++;
                            if (mv_key < heap_key[child]) begin
                                settled = 1'b1;
                            end else begin
                                heap_key[pos] = heap_key[child];
                                heap_tag[pos] = heap_tag[child];
                                pos = child;
                            end
                        end
                        heap_key[pos] = mv_key;
                        heap_tag[pos] = mv_tag;
                    end
                end
                OP_CLEAR: begin
                    fill = 0;
                end
                default: begin
                end
            endcase
            res.entry_count = COUNT_W'(fill);
            owed_results.push_back(res);
        endfunction

        function void compare_field(string field, logic [KEY_PORT_W-1:0] want,
                                    logic [KEY_PORT_W-1:0] got);
            if (got !== want) begin
                failures++;
                $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                         $time, field, want, got);
            end
        endfunction

        // match one accepted result against the oldest owed one
        function void check_result(t_heap_result got);
            t_heap_result want;
            if (owed_results.size() == 0) begin
                failures++;
                $display("%0t ns: unexpected result, expected none, actual %0h", $time, got);
            end else begin
                want = owed_results.pop_front();
                compare_field("out_key", want.res_key, got.res_key);
                compare_field("out_tag", want.res_tag, got.res_tag);
                compare_field("was_empty", want.was_empty, got.was_empty);
                compare_field("overflow", want.overflow, got.overflow);
                compare_field("entry_count", want.entry_count, got.entry_count);
            end
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    logic [OP_W-1:0]       i_operation = OP_NOP;
    logic [KEY_PORT_W-1:0] i_key       = '0;
    logic [TAG_W-1:0]      i_tag       = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [KEY_PORT_W-1:0] o_out_key;
    logic [TAG_W-1:0]      o_out_tag;
    logic                  o_was_empty;
    logic                  o_overflow;
    logic [COUNT_W-1:0]    o_entry_count;

    heap_scoreboard sb;
    bit             idle_en  = 1'b1;
    bit             hold_req = 1'b0;
    int unsigned    cycle_count = 0;

    binary_min_heap_queue_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_key         (i_key),
        .i_tag         (i_tag),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_key     (o_out_key),
        .o_out_tag     (o_out_tag),
        .o_was_empty   (o_was_empty),
        .o_overflow    (o_overflow),
        .o_entry_count (o_entry_count)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("binary_min_heap_queue_top test failed");
            $finish;
        end
    end

    // weighted operation choice, the rest of the range is no-op
    function automatic t_op pick_op(int unsigned ins_w, int unsigned rem_w, int unsigned clr_w);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < ins_w)
            return OP_INSERT;
        else if (r < ins_w + rem_w)
            return OP_REMOVE;
        else if (r < ins_w + rem_w + clr_w)
            return OP_CLEAR;
        return OP_NOP;
    endfunction

    // keys: full range, clustered small values for ties, and values near both ends
    function automatic logic [KEY_PORT_W-1:0] pick_key();
        logic [KEY_PORT_W-1:0] k;
        case ($urandom_range(0, 3))
            0: k = $urandom;
            1: k = $urandom_range(0, 15);
            2: k = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3)
                                               : $urandom_range(0, 3);
            default: k = $urandom_range(0, 1000);
        endcase
        return k;
    endfunction

    // offer one item and hold it until the transfer
    task automatic send_item(input t_op op, input logic [KEY_PORT_W-1:0] key,
                             input logic [TAG_W-1:0] tag);
        int unsigned gap;
        gap = 0;
        if (idle_en && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 6);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_key       <= key;
        i_tag       <= tag;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_transfer(op, key, tag);
    endtask

    // stop offering and wait for every owed result
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // result side: random stall bursts plus one long hold-off on request
    initial begin : result_sink
        int unsigned  burst_left;
        int unsigned  hold_left;
        t_heap_result got;
        burst_left = 0;
        hold_left  = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                got.res_key     = o_out_key;
                got.res_tag     = o_out_tag;
                got.was_empty   = o_was_empty;
                got.overflow    = o_overflow;
                got.entry_count = o_entry_count;
                sb.check_result(got);
            end
            if (hold_left != 0) begin
                hold_left--;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end else if (burst_left != 0) begin
                burst_left--;
            end else if (idle_en && $urandom_range(0, 4) == 0) begin
                burst_left = $urandom_range(1, 6);
            end
            i_out_stall <= (hold_left != 0) || (burst_left != 0);
        end
    end

    // stimulus
    initial begin : stimulus
        int i;
        sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty heap cases, extreme keys and tags, ties, clear with entries
        send_item(OP_REMOVE, 32'h0000_0000, 9'h000);
        send_item(OP_NOP,    32'hFFFF_FFFF, 9'h1FF);
        send_item(OP_CLEAR,  32'h1234_5678, 9'h0AB);
        send_item(OP_INSERT, 32'hFFFF_FFFF, 9'h1FF);
        send_item(OP_INSERT, 32'h0000_0000, 9'h000);
        send_item(OP_INSERT, 32'h0000_0000, 9'h005);
        send_item(OP_INSERT, 32'h8000_0000, 9'h100);
        send_item(OP_INSERT, 32'h7FFF_FFFF, 9'h0FF);
        send_item(OP_INSERT, 32'hFFFF_FFFF, 9'h001);
        send_item(OP_NOP,    32'h5555_5555, 9'h155);
        send_item(OP_REMOVE, 32'h0000_0000, 9'h000);
        send_item(OP_REMOVE, 32'hFFFF_FFFF, 9'h1FF);
        send_item(OP_REMOVE, 32'h0000_0000, 9'h000);
        send_item(OP_REMOVE, 32'h0000_0000, 9'h000);
        send_item(OP_CLEAR,  32'h0000_0000, 9'h000);
        send_item(OP_REMOVE, 32'h0000_0000, 9'h000);
        send_item(OP_INSERT, 32'h5555_5555, 9'h0AA);
        send_item(OP_INSERT, 32'hAAAA_AAAA, 9'h155);
        send_item(OP_INSERT, 32'h5555_5555, 9'h1FF);
        send_item(OP_REMOVE, 32'h0000_0000, 9'h000);
        send_item(OP_REMOVE, 32'h0000_0000, 9'h000);
        send_item(OP_REMOVE, 32'h0000_0000, 9'h000);
        send_item(OP_REMOVE, 32'h0000_0000, 9'h000);

        // mixed traffic on a shallow heap
        for (i = 0; i < 60; i++)
            send_item(pick_op(48, 40, 3), pick_key(), TAG_W'($urandom_range(0, 511)));

        // fill to capacity while the result side holds off for a long stretch
        hold_req = 1'b1;
        while (sb.fill < HEAP_CAP)
            send_item(pick_op(92, 5, 0), pick_key(), TAG_W'($urandom_range(0, 511)));
        for (i = 0; i < 6; i++)
            send_item(OP_INSERT, pick_key(), TAG_W'($urandom_range(0, 511)));
        send_item(OP_REMOVE, pick_key(), TAG_W'($urandom_range(0, 511)));
        send_item(OP_INSERT, pick_key(), TAG_W'($urandom_range(0, 511)));
        send_item(OP_INSERT, pick_key(), TAG_W'($urandom_range(0, 511)));

        // sender pause with a full heap
        wait_drained();

        // drain the full heap down to empty
        while (sb.fill != 0)
            send_item(pick_op(8, 90, 0), pick_key(), TAG_W'($urandom_range(0, 511)));
        send_item(OP_REMOVE, pick_key(), TAG_W'($urandom_range(0, 511)));
        send_item(OP_REMOVE, pick_key(), TAG_W'($urandom_range(0, 511)));

        // last stretch with no idling, heavy key ties
        idle_en = 1'b0;
        for (i = 0; i < 80; i++)
            send_item(pick_op(50, 42, 2), $urandom_range(0, 3),
                      TAG_W'($urandom_range(0, 511)));

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("binary_min_heap_queue_top test passed");
        end else begin
            $display("binary_min_heap_queue_top test failed");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/bmhq_pkg.sv
hdl/bmhq_ctrl.sv
hdl/bmhq_datapath.sv
hdl/binary_min_heap_queue_top.sv
test/binary_min_heap_queue_top_tb.sv
